FILE: sv/scalar_kalman_filter_defines.svh
// Assertion helpers for the scalar Kalman filter.
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define SKF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scalar_kalman_filter check failed");
`define SKF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scalar_kalman_filter check failed");
`else
`define SKF_ASSERT_SAME(label, clk, rst, ante, cons)
`define SKF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/skf_pkg.sv
package skf_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;

  localparam logic [30:0] PROCESS_NOISE_RESET      = 31'd6554;
  localparam logic [30:0] MEASUREMENT_NOISE_RESET  = 31'd6554;
  localparam logic [30:0] INITIAL_COVARIANCE_RESET = 31'd6554;
  localparam logic [31:0] INITIAL_ESTIMATE_RESET   = 32'd0;

  localparam logic [16:0] GAIN_MAX = 17'h1FFFF;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MEASUREMENT_NOISE  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_COVARIANCE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_ESTIMATE   = 3'd3;

  typedef struct packed {
    logic signed [31:0] measurement;
    logic               last;
  } meas_t;

  typedef struct packed {
    logic signed [31:0] estimate;
    logic [16:0]        gain;
  } result_t;

endpackage

FILE: sv/scalar_kalman_filter.sv
// Scalar Kalman filter over a stream of signed fixed-point measurements.
// A measurement request (meas, with a last flag) is taken on meas_valid when
// meas_stall is low; each one yields exactly one result request (estimate and
// gain) on result_valid, taken when result_stall is low.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// q, r and the starting covariance and estimate; cfg_ready is always high, and
// writes are expected only while no measurement is in flight.
// One measurement at a time is processed. After acceptance it passes a load
// state and a divider setup state, a bit-serial restoring divider for the
// gain, a multiplier setup state, two shift-and-add multipliers run side by
// side, and a final rounding state that registers the result. A new
// measurement is taken only once the filter is back in idle, after the last
// one is through.
// The result sits in an output register; while it waits under result_stall
// the next measurement is already accepted and computed, and only the final
// rounding state holds until the register is free.
// Reset restores the register defaults, drops any pending result and makes the
// next measurement start from the configured covariance and estimate, as after
// a measurement marked last.
`include "scalar_kalman_filter_defines.svh"

module scalar_kalman_filter #(
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                meas_valid,
  output logic                                meas_stall,
  input  skf_pkg::meas_t                      meas,
  output logic                                result_valid,
  input  logic                                result_stall,
  output skf_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [skf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_data
);
  import skf_pkg::*;

  localparam int GW  = FRAC_BITS + 1;
  localparam int CW  = $clog2(GW);
  localparam int PXW = 33 + GW;
  localparam int PPW = 31 + GW;
  localparam int GXW = GW + 17;
  localparam logic [GW-1:0]  ONE    = GW'(1) << FRAC_BITS;
  localparam logic [PXW-1:0] HALF_X = PXW'(1) << (FRAC_BITS - 1);
  localparam logic [PPW-1:0] HALF_P = PPW'(1) << (FRAC_BITS - 1);
  localparam logic [CW-1:0]  LAST_STEP = CW'(GW - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_DSET, S_DIV, S_MSET, S_MUL, S_FIN
  } state_t;

  state_t state;

  logic [30:0]        q_reg;
  logic [30:0]        r_reg;
  logic [30:0]        p_init;
  logic signed [31:0] x_init;

  logic [30:0]        cov;
  logic signed [31:0] est;
  logic               restart;

  logic signed [31:0] z;
  logic               last_r;
  logic [30:0]        p1;
  logic signed [31:0] x;

  logic [31:0]        denom;
  logic [32:0]        rem;
  logic [GW-1:0]      quot;
  logic [CW-1:0]      count;

  logic [GW-1:0]      gain;
  logic [GW-1:0]      mpx;
  logic [GW-1:0]      mpp;
  logic signed [PXW-1:0] mcx;
  logic [PPW-1:0]     mcp;
  logic signed [PXW-1:0] accx;
  logic [PPW-1:0]     accp;

  logic [30:0]        p_src;
  logic signed [31:0] x_src;
  logic [31:0]        p_sum;
  logic               rem_ge;
  logic [32:0]        rem_sub;
  logic [31:0]        rem_sel;
  logic [GW-1:0]      gain_v;
  logic signed [32:0] dz;
  logic [PXW-1:0]     sx;
  logic signed [33:0] delta;
  logic signed [34:0] nx;
  logic signed [31:0] est_sat;
  logic [PPW-1:0]     sp;
  logic [31:0]        np;
  logic [30:0]        newp;
  logic [GXW-1:0]     gain_ext;
  logic [16:0]        gain_out;
  logic               out_busy;

  assign meas_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_busy   = result_valid && result_stall;

  always_comb begin
    p_src   = restart ? p_init : cov;
    x_src   = restart ? x_init : est;
    p_sum   = {1'b0, p_src} + {1'b0, q_reg};
    rem_ge  = (rem >= {1'b0, denom});
    rem_sub = rem - {1'b0, denom};
    rem_sel = rem_ge ? rem_sub[31:0] : rem[31:0];
    gain_v  = (denom == 32'd0) ? '0 : quot;
    dz      = 33'(z) - 33'(x);
    sx      = accx + HALF_X;
    delta   = sx[PXW-1:FRAC_BITS];
    nx      = 35'(x) + 35'(delta);
    if (nx[34] && !(nx[33] && nx[32] && nx[31])) begin
      est_sat = 32'sh8000_0000;
    end else if (!nx[34] && (nx[33] || nx[32] || nx[31])) begin
      est_sat = 32'sh7FFF_FFFF;
    end else begin
      est_sat = nx[31:0];
    end
    sp   = accp + HALF_P;
    np   = sp[PPW-1:FRAC_BITS];
    newp = (np > {1'b0, p1}) ? p1 : np[30:0];
    gain_ext = GXW'(gain);
    gain_out = (gain_ext > GXW'(GAIN_MAX)) ? GAIN_MAX : gain_ext[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      restart      <= 1'b1;
      count        <= '0;
      q_reg        <= PROCESS_NOISE_RESET;
      r_reg        <= MEASUREMENT_NOISE_RESET;
      p_init       <= INITIAL_COVARIANCE_RESET;
      x_init       <= INITIAL_ESTIMATE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PROCESS_NOISE:      q_reg  <= cfg_data[30:0];
          REG_MEASUREMENT_NOISE:  r_reg  <= cfg_data[30:0];
          REG_INITIAL_COVARIANCE: p_init <= cfg_data[30:0];
          REG_INITIAL_ESTIMATE:   x_init <= cfg_data;
          default: ;
        endcase
      end

      if (result_valid && !result_stall && state != S_FIN) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (meas_valid) begin
            z      <= meas.measurement;
            last_r <= meas.last;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          p1    <= p_sum[31] ? 31'h7FFF_FFFF : p_sum[30:0];
          x     <= x_src;
          state <= S_DSET;
        end
        S_DSET: begin
          denom <= {1'b0, p1} + {1'b0, r_reg};
          rem   <= {2'b00, p1};
          quot  <= '0;
          count <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= {rem_sel, 1'b0};
          quot <= {quot[GW-2:0], rem_ge};
          if (count == LAST_STEP) begin
            state <= S_MSET;
          end else begin
            count <= count + CW'(1);
          end
        end
        S_MSET: begin
          gain  <= gain_v;
          mpx   <= gain_v;
          mpp   <= ONE - gain_v;
          mcx   <= PXW'(dz);
          mcp   <= PPW'(p1);
          accx  <= '0;
          accp  <= '0;
          count <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          accx <= accx + (mpx[0] ? mcx : '0);
          accp <= accp + (mpp[0] ? mcp : '0);
          mcx  <= mcx <<< 1;
          mcp  <= mcp << 1;
          mpx  <= mpx >> 1;
          mpp  <= mpp >> 1;
          if (count == LAST_STEP) begin
            state <= S_FIN;
          end else begin
            count <= count + CW'(1);
          end
        end
        S_FIN: begin
          if (!out_busy) begin
            result.estimate <= est_sat;
            result.gain     <= gain_out;
            result_valid    <= 1'b1;
            est             <= est_sat;
            cov             <= newp;
            restart         <= last_r;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SKF_ASSERT_NEXT(a_accept_starts_load, clk, rst, meas_valid && !meas_stall, state == S_LOAD)
  `SKF_ASSERT_NEXT(a_fin_delivers, clk, rst, state == S_FIN && !out_busy, result_valid && state == S_IDLE)
  `SKF_ASSERT_SAME(a_step_bound, clk, rst, state == S_DIV || state == S_MUL, count <= LAST_STEP)
  `SKF_ASSERT_NEXT(a_div_to_mul, clk, rst, state == S_DIV && count == LAST_STEP, state == S_MSET)

endmodule
